### hw/rtl/tcrm_pkg.sv
`default_nettype none

package tcrm_pkg;

    // Depth of each running window (valid range 3 to 15).
    localparam int WINDOW = 5;

    localparam int SAMPLE_W = 12;
    localparam int CHANNELS = 3;

    // Slot pointer and rank counts both hold values 0 .. WINDOW-1.
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RANK_W = SLOT_W;

    // Rank of the selected element; the upper median for an even window.
    localparam int MEDIAN_RANK = WINDOW / 2;

    // Channel positions within the packed window set.
    localparam int CH_PEDAL_A = 0;
    localparam int CH_PEDAL_B = 1;
    localparam int CH_BRAKE   = 2;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [RANK_W-1:0]   rank_t;

    typedef sample_t [WINDOW-1:0]   window_t;
    typedef window_t [CHANNELS-1:0] window_set_t;
    typedef sample_t [CHANNELS-1:0] sample_set_t;

endpackage

`default_nettype wire

### hw/rtl/tcrm_sample_if.sv
`default_nettype none

interface tcrm_sample_if;

    logic                  valid;
    logic                  ready;
    tcrm_pkg::sample_t     pedal_a_sample;
    tcrm_pkg::sample_t     pedal_b_sample;
    tcrm_pkg::sample_t     brake_sample;

    modport source (
        output valid,
        input  ready,
        output pedal_a_sample,
        output pedal_b_sample,
        output brake_sample
    );

    modport sink (
        input  valid,
        output ready,
        input  pedal_a_sample,
        input  pedal_b_sample,
        input  brake_sample
    );

endinterface

`default_nettype wire

### hw/rtl/tcrm_median_if.sv
`default_nettype none

interface tcrm_median_if;

    logic                  valid;
    logic                  ready;
    tcrm_pkg::sample_t     pedal_a_median;
    tcrm_pkg::sample_t     pedal_b_median;
    tcrm_pkg::sample_t     brake_median;

    modport source (
        output valid,
        input  ready,
        output pedal_a_median,
        output pedal_b_median,
        output brake_median
    );

    modport sink (
        input  valid,
        output ready,
        input  pedal_a_median,
        input  pedal_b_median,
        input  brake_median
    );

endinterface

`default_nettype wire

### hw/rtl/tcrm_window.sv
`default_nettype none

// Three circular sample windows sharing one write slot pointer.
module tcrm_window (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  write,
    input  wire tcrm_pkg::sample_set_t samples,
    output tcrm_pkg::window_set_t      windows
);

    tcrm_pkg::window_set_t windows_reg;
    tcrm_pkg::window_set_t windows_next;
    tcrm_pkg::slot_t       slot_reg;
    tcrm_pkg::slot_t       slot_next;

    always_comb
    begin
        windows_next = windows_reg;
        slot_next    = slot_reg;
        if (write)
        begin
            for (int c = 0; c < tcrm_pkg::CHANNELS; c++)
            begin
                windows_next[c][slot_reg] = samples[c];
            end
            if (slot_reg == tcrm_pkg::slot_t'(tcrm_pkg::WINDOW - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + tcrm_pkg::slot_t'(1);
            end
        end
    end

    // The windows are state that the medians depend on, so reset clears them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            windows_reg <= '0;
            slot_reg    <= '0;
        end
        else
        begin
            windows_reg <= windows_next;
            slot_reg    <= slot_next;
        end
    end

    assign windows = windows_reg;

    a_slot_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        slot_reg <= tcrm_pkg::slot_t'(tcrm_pkg::WINDOW - 1)
    ) else $error("write slot left the window range");

endmodule

`default_nettype wire

### hw/rtl/tcrm_median.sv
`default_nettype none

// Rank selection: each element counts the entries ordered before it, with
// ties broken by position, so the ranks form a permutation and exactly one
// element carries the median rank.
module tcrm_median (
    input  wire tcrm_pkg::window_t window,
    output tcrm_pkg::sample_t      median
);

    logic [tcrm_pkg::WINDOW-1:0] ahead [tcrm_pkg::WINDOW];
    tcrm_pkg::rank_t             rank  [tcrm_pkg::WINDOW];
    logic [tcrm_pkg::WINDOW-1:0] hit;

    always_comb
    begin
        median = '0;
        for (int i = 0; i < tcrm_pkg::WINDOW; i++)
        begin
            for (int j = 0; j < tcrm_pkg::WINDOW; j++)
            begin
                if (j < i)
                begin
                    ahead[i][j] = (window[j] <= window[i]);
                end
                else if (j > i)
                begin
                    ahead[i][j] = (window[j] < window[i]);
                end
                else
                begin
                    ahead[i][j] = 1'b0;
                end
            end
            rank[i] = tcrm_pkg::rank_t'($countones(ahead[i]));
            hit[i]  = (rank[i] == tcrm_pkg::rank_t'(tcrm_pkg::MEDIAN_RANK));
            median  = median | ({tcrm_pkg::SAMPLE_W{hit[i]}} & window[i]);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/three_channel_running_median.sv
`default_nettype none

// Channel    Modport   Payload (12 bits unsigned each)
// samples    sink      pedal_a_sample, pedal_b_sample, brake_sample
// medians    source    pedal_a_median, pedal_b_median, brake_median
//
// One request is taken every cycle while the sample channel is not stalled;
// its samples enter the windows first and its medians the result register next.
// The window registers act as the input register, the medians are formed
// by the rank network between them and the result register.
// Reset clears all three windows and the slot pointer at once, so the
// zeros count in the median until they have been overwritten.
// The sample channel stalls only while the result register holds medians
// that have not been taken and a further request still waits to be ranked.
module three_channel_running_median (
    input  wire logic      clk,
    input  wire logic      rst_n,
    tcrm_sample_if.sink    samples,
    tcrm_median_if.source  medians
);

    // Set while the windows hold the state left by a request whose medians
    // have not yet been captured in the result register.
    logic pending_reg;
    logic pending_next;
    logic out_valid_reg;
    logic out_valid_next;

    logic accept;
    logic advance;

    tcrm_pkg::sample_set_t in_samples;
    tcrm_pkg::window_set_t windows;
    tcrm_pkg::sample_set_t medians_comb;
    tcrm_pkg::sample_set_t medians_reg;

    // The rank stage moves on when a request is pending and the result register is
    // empty or is being emptied in this cycle.
    assign advance = pending_reg && (!out_valid_reg || medians.ready);

    // A new request may overwrite the windows in the same cycle that the
    // old window contents are ranked, since the result register samples
    // the medians of the contents before the edge.
    assign samples.ready = !pending_reg || advance;
    assign accept        = samples.valid && samples.ready;

    assign in_samples[tcrm_pkg::CH_PEDAL_A] = samples.pedal_a_sample;
    assign in_samples[tcrm_pkg::CH_PEDAL_B] = samples.pedal_b_sample;
    assign in_samples[tcrm_pkg::CH_BRAKE]   = samples.brake_sample;

    tcrm_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .write   (accept),
        .samples (in_samples),
        .windows (windows)
    );

    // One rank network per channel, all working in parallel.
    for (genvar c = 0; c < tcrm_pkg::CHANNELS; c++)
    begin : g_median
        tcrm_median u_median (
            .window (windows[c]),
            .median (medians_comb[c])
        );
    end

    always_comb
    begin
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (medians.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            pending_next = 1'b1;
        end
        else if (advance)
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset: it is qualified by the valid flag.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            medians_reg <= medians_comb;
        end
    end

    assign medians.valid          = out_valid_reg;
    assign medians.pedal_a_median = medians_reg[tcrm_pkg::CH_PEDAL_A];
    assign medians.pedal_b_median = medians_reg[tcrm_pkg::CH_PEDAL_B];
    assign medians.brake_median   = medians_reg[tcrm_pkg::CH_BRAKE];

    a_accept_pends: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> pending_reg
    ) else $error("accepted request left no pending median");

    a_advance_fills: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg
    ) else $error("ranked medians were not presented");

    a_full_holds_windows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pending_reg && out_valid_reg && !medians.ready) |=> $stable(windows)
    ) else $error("windows changed while the pipeline was full");

endmodule

`default_nettype wire
